// ----- design/lcdseq_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lcdseq_pkg
// Types, codes and constants of the 4-bit character LCD sequencer.
// ----------------------------------------------------------------------------
package lcdseq_pkg;

  typedef enum logic [2:0] {
    ACT_INIT   = 3'd0,
    ACT_CLEAR  = 3'd1,
    ACT_CMD    = 3'd2,
    ACT_DATA   = 3'd3,
    ACT_CURSOR = 3'd4,
    ACT_PRINT  = 3'd5
  } action_e;

  typedef enum logic [1:0] {
    REG_SETTLE    = 2'd0,
    REG_INIT_WAIT = 2'd1,
    REG_POWER_UP  = 2'd2
  } reg_idx_e;

  typedef enum logic [1:0] {
    F_IDLE,
    F_CONV,
    F_PUSH
  } front_state_e;

  localparam logic [7:0]  CMD_CLEAR      = 8'h01;
  localparam logic [7:0]  CMD_SET_DDRAM  = 8'h80;
  localparam logic [6:0]  ROW1_OFFSET    = 7'h40;
  localparam logic [7:0]  ASCII_ZERO     = 8'h30;
  localparam logic [7:0]  ASCII_SPACE    = 8'h20;
  // x / 10 == (x * 0xCCCD) >> 19 for every 16-bit x
  localparam logic [15:0] DIV10_RECIP    = 16'hCCCD;
  localparam int unsigned DIV10_SHIFT    = 19;
  localparam logic [15:0] NUM_1000       = 16'd1000;
  localparam logic [15:0] NUM_100        = 16'd100;
  localparam logic [15:0] NUM_10         = 16'd10;
  localparam logic [3:0]  LAST_IDX_INIT  = 4'd9;
  localparam logic [3:0]  LAST_IDX_PRINT = 4'd7;
  localparam logic [3:0]  LAST_IDX_BYTE  = 4'd1;
  localparam logic [16:0] WAIT_AFTER_MAX = 17'h1FFFF;

  typedef struct packed {
    logic [2:0]  action;
    logic [7:0]  byte_value;
    logic [5:0]  column;
    logic        line_index;
    logic [15:0] number;
  } item_t;

  typedef struct packed {
    logic        register_select;
    logic [3:0]  nibble;
    logic [19:0] wait_before_us;
    logic [16:0] wait_after_us;
    logic        last;
  } result_t;

  typedef struct packed {
    logic [9:0]  nibble_settle_us;
    logic [16:0] init_command_wait_us;
    logic [19:0] power_up_wait_us;
  } cfg_t;

  // one classified action waiting for the bus side
  typedef struct packed {
    logic            rs;
    logic            is_init;
    logic [3:0]      last_idx;
    logic [3:0][7:0] bytes;
  } job_t;

  function automatic logic [7:0] init_cmd(input logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0:    c = 8'h02;
      3'd1:    c = 8'h01;
      3'd2:    c = 8'h0C;
      3'd3:    c = 8'h14;
      3'd4:    c = 8'h28;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

// ----- design/lcdseq_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lcdseq_front
// Accepts display actions, turns each into a job of bytes; print unsigned
// runs one decimal digit per cycle.
// ----------------------------------------------------------------------------
module lcdseq_front import lcdseq_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  start,
  input  wire item_t item_i,
  output logic       busy,
  input  wire logic  q_full_i,
  output logic       push_o,
  output job_t       job_o
);

  front_state_e state_q, state_d;
  job_t         job_q;
  job_t         job_new;
  logic [15:0]  num_q;
  logic [1:0]   cnt_q;
  logic [3:0]   blank_q;
  logic         accept;
  logic         act_valid;
  logic [6:0]   addr;
  logic [31:0]  prod;
  logic [12:0]  quot;
  logic [15:0]  rem;
  logic [1:0]   pos;
  logic [7:0]   digit_char;

  assign accept = start && !busy;
  assign job_o  = job_q;

  // classify the incoming action
  always_comb begin
    job_new          = '0;
    job_new.last_idx = LAST_IDX_BYTE;
    act_valid        = item_i.action inside {ACT_INIT, ACT_CLEAR, ACT_CMD, ACT_DATA,
                                             ACT_CURSOR, ACT_PRINT};
    addr             = {1'b0, item_i.column} + (item_i.line_index ? ROW1_OFFSET : 7'd0);
    case (action_e'(item_i.action))
      ACT_INIT: begin
        job_new.is_init  = 1'b1;
        job_new.last_idx = LAST_IDX_INIT;
      end
      ACT_CLEAR: begin
        job_new.bytes[0] = CMD_CLEAR;
      end
      ACT_CMD: begin
        job_new.bytes[0] = item_i.byte_value;
      end
      ACT_DATA: begin
        job_new.rs       = 1'b1;
        job_new.bytes[0] = item_i.byte_value;
      end
      ACT_CURSOR: begin
        job_new.bytes[0] = CMD_SET_DDRAM | {1'b0, addr};
      end
      ACT_PRINT: begin
        job_new.rs       = 1'b1;
        job_new.last_idx = LAST_IDX_PRINT;
      end
      default: begin
        job_new = '0;
      end
    endcase
  end

  // one digit per cycle, least significant first
  always_comb begin
    prod       = num_q * DIV10_RECIP;
    quot       = prod[DIV10_SHIFT +: 13];
    rem        = num_q - {quot, 3'b000} - {2'b00, quot, 1'b0};
    pos        = 2'd3 - cnt_q;
    digit_char = blank_q[pos] ? ASCII_SPACE : (ASCII_ZERO | {4'h0, rem[3:0]});
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      F_IDLE, F_PUSH: begin
        if (!busy) begin
          if (accept && act_valid) begin
            state_d = (action_e'(item_i.action) == ACT_PRINT) ? F_CONV : F_PUSH;
          end else begin
            state_d = F_IDLE;
          end
        end
      end
      F_CONV: begin
        if (cnt_q == 2'd3) begin
          state_d = F_PUSH;
        end
      end
      default: begin
        state_d = F_IDLE;
      end
    endcase
  end

  // outputs
  always_comb begin
    case (state_q)
      F_IDLE: begin
        busy   = 1'b0;
        push_o = 1'b0;
      end
      F_PUSH: begin
        busy   = q_full_i;
        push_o = !q_full_i;
      end
      default: begin
        busy   = 1'b1;
        push_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      cnt_q   <= 2'd0;
    end else begin
      state_q <= state_d;
      if (accept) begin
        cnt_q <= 2'd0;
      end else if (state_q == F_CONV) begin
        cnt_q <= cnt_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      job_q   <= job_new;
      num_q   <= item_i.number;
      blank_q <= {1'b0, item_i.number < NUM_10, item_i.number < NUM_100,
                  item_i.number < NUM_1000};
    end else if (state_q == F_CONV) begin
      num_q            <= {3'b000, quot};
      job_q.bytes[pos] <= digit_char;
    end
  end

endmodule
`default_nettype wire

// ----- design/lcdseq_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lcdseq_queue
// Short job FIFO between the front and the bus side.
// ----------------------------------------------------------------------------
module lcdseq_queue import lcdseq_pkg::*; #(
  parameter int unsigned DEPTH = 2
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire job_t job_i,
  output logic      full_o,
  input  wire logic pop_i,
  output logic      valid_o,
  output job_t      job_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  job_t          mem_q [DEPTH];
  logic [PW-1:0] wptr_q, rptr_q;
  logic [CW-1:0] cnt_q;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign valid_o = (cnt_q != '0);
  assign job_o   = mem_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= (wptr_q == PW'(DEPTH - 1)) ? '0 : wptr_q + PW'(1);
      end
      if (pop_i) begin
        rptr_q <= (rptr_q == PW'(DEPTH - 1)) ? '0 : rptr_q + PW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= job_i;
    end
  end

endmodule
`default_nettype wire

// ----- design/lcdseq_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lcdseq_back
// Plays a job out as nibble transfers, one per cycle, with their waits.
// ----------------------------------------------------------------------------
module lcdseq_back import lcdseq_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire cfg_t cfg_i,
  input  wire logic q_valid_i,
  input  wire job_t q_job_i,
  output logic      pop_o,
  output logic      result_valid_o,
  output result_t   result_o
);

  logic        active_q;
  job_t        job_q;
  logic [3:0]  idx_q;
  logic        res_valid_q;
  result_t     res_q;
  result_t     res_d;
  logic        at_last;
  logic [2:0]  byte_idx;
  logic [7:0]  cur_byte;
  logic [17:0] init_sum;
  logic [16:0] init_after;

  assign at_last        = (idx_q == job_q.last_idx);
  assign pop_o          = q_valid_i && (!active_q || at_last);
  assign result_valid_o = res_valid_q;
  assign result_o       = res_q;

  always_comb begin
    byte_idx   = idx_q[3:1];
    cur_byte   = job_q.is_init ? init_cmd(byte_idx) : job_q.bytes[byte_idx[1:0]];
    init_sum   = {8'h00, cfg_i.nibble_settle_us} + {1'b0, cfg_i.init_command_wait_us};
    init_after = init_sum[17] ? WAIT_AFTER_MAX : init_sum[16:0];

    res_d.register_select = job_q.rs;
    res_d.nibble          = idx_q[0] ? cur_byte[3:0] : cur_byte[7:4];
    res_d.wait_before_us  = (job_q.is_init && idx_q == 4'd0) ? cfg_i.power_up_wait_us : '0;
    // second nibble of an init command carries the extra command wait
    res_d.wait_after_us   = (job_q.is_init && idx_q[0]) ? init_after
                                                        : {7'h00, cfg_i.nibble_settle_us};
    res_d.last            = at_last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      idx_q       <= 4'd0;
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= active_q;
      if (pop_o) begin
        active_q <= 1'b1;
        idx_q    <= 4'd0;
      end else if (active_q) begin
        if (at_last) begin
          active_q <= 1'b0;
        end
        idx_q <= idx_q + 4'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      job_q <= q_job_i;
    end
    if (active_q) begin
      res_q <= res_d;
    end
  end

  a_idx_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_q |-> idx_q <= job_q.last_idx)
    else $error("nibble index ran past the end of the job");

  a_before_init_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && res_q.wait_before_us != '0) |-> $past(job_q.is_init && idx_q == 4'd0))
    else $error("power-up wait outside the first init nibble");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> q_valid_i && (!active_q || at_last))
    else $error("job taken while another is still being sent");

endmodule
`default_nettype wire

// ----- design/char_lcd_four_bit_sequencer.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// char_lcd_four_bit_sequencer
// Turns display actions into 4-bit LCD bus nibble transfers.
// ----------------------------------------------------------------------------
// Usage:
//   An action item is taken when start is high and busy is low. The front
//   classifies it into a job (print unsigned first converts its number into
//   four decimal digits) and queues it; the back sends one nibble per cycle on
//   result_o, each marked by a one-cycle result_valid_o pulse, last set on
//   the final nibble of the action. Unused action codes produce nothing.
//   An action is 2, 8 or 10 nibbles long, so the sustained item rate is set
//   by the nibble count; the front takes a new item while the back is busy
//   until the job queue (QUEUE_DEPTH entries) is full, but not while it
//   converts a print unsigned.
//   The receiver cannot stall; results leave as produced.
//   Timing registers sit on an APB port at byte addresses 0, 4 and 8 and
//   should be written only while the block is idle. Reset clears the queue
//   and control and loads the default waits (100, 20000, 450000 us).
// ----------------------------------------------------------------------------
module char_lcd_four_bit_sequencer import lcdseq_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  input  wire item_t       item_i,
  output logic             busy,
  output logic             result_valid_o,
  output result_t          result_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  cfg_t cfg_q;
  logic cfg_we;
  logic push;
  logic q_full;
  logic q_valid;
  logic pop;
  job_t front_job;
  job_t head_job;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.nibble_settle_us     <= 10'd100;
      cfg_q.init_command_wait_us <= 17'd20000;
      cfg_q.power_up_wait_us     <= 20'd450000;
    end else if (cfg_we) begin
      case (reg_idx_e'(paddr[3:2]))
        REG_SETTLE:    cfg_q.nibble_settle_us     <= pwdata[9:0];
        REG_INIT_WAIT: cfg_q.init_command_wait_us <= pwdata[16:0];
        REG_POWER_UP:  cfg_q.power_up_wait_us     <= pwdata[19:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx_e'(paddr[3:2]))
      REG_SETTLE:    prdata = {22'h0, cfg_q.nibble_settle_us};
      REG_INIT_WAIT: prdata = {15'h0, cfg_q.init_command_wait_us};
      REG_POWER_UP:  prdata = {12'h0, cfg_q.power_up_wait_us};
      default:       prdata = '0;
    endcase
  end

  lcdseq_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .item_i   (item_i),
    .busy     (busy),
    .q_full_i (q_full),
    .push_o   (push),
    .job_o    (front_job)
  );

  lcdseq_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (front_job),
    .full_o  (q_full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .job_o   (head_job)
  );

  lcdseq_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .q_valid_i      (q_valid),
    .q_job_i        (head_job),
    .pop_o          (pop),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

endmodule
`default_nettype wire

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the 4-bit character LCD sequencer. Action items go
// in on the start/busy handshake and every nibble transfer on the result
// strobe is matched, field by field, against a local model of the nibble
// stream. Timing registers are set over APB between phases of random items.
// ----------------------------------------------------------------------------
module tb_top;
  import lcdseq_pkg::*;

  localparam int unsigned   PHASE_ITEMS    = 28;
  localparam int unsigned   NUM_PHASES     = 5;
  localparam int unsigned   SETTLE_GAP     = 16;  // covers the deepest pipeline path
  localparam int unsigned   WATCHDOG_LIMIT = 5000;
  localparam int unsigned   REPORT_LIMIT   = 10;
  localparam logic [2:0]    ACT_SPARE_LO   = 3'd6;
  localparam logic [2:0]    ACT_SPARE_HI   = 3'd7;
  localparam logic [7:0]    SET_ADDR_CMD   = 8'h80;
  localparam logic [7:0]    CLEAR_CMD      = 8'h01;
  localparam logic [6:0]    LINE1_BASE     = 7'h40;
  localparam logic [17:0]   AFTER_CEILING  = 18'h1FFFF;
  // init command bytes, first sent at index 0
  localparam logic [4:0][7:0] INIT_SEQ = {8'h28, 8'h14, 8'h0C, 8'h01, 8'h02};

  typedef enum logic [1:0] {
    ROW_PREDICT,
    ROW_BYTE,
    ROW_NONE
  } row_kind_e;

  typedef struct {
    row_kind_e  kind;
    item_t      it;
    logic       rs;
    logic [7:0] b;
  } dir_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        start;
  item_t       item_i;
  logic        busy;
  logic        result_valid_o;
  result_t     result_o;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  // shadow copy of the timing registers
  logic [9:0]  settle_us;
  logic [16:0] init_wait_us;
  logic [19:0] power_up_us;

  result_t     nibble_q[$];
  dir_row_t    directed_rows[$];
  int unsigned err_count;
  int unsigned idle_cycles;
  result_t     got_r;
  result_t     want_r;

  char_lcd_four_bit_sequencer dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .item_i         (item_i),
    .busy           (busy),
    .result_valid_o (result_valid_o),
    .result_o       (result_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // --------------------------------------------------------------------------
  // nibble stream model
  // --------------------------------------------------------------------------
  function automatic void push_nibble(logic rs, logic [3:0] nib, logic [19:0] pre_wait,
                                      logic [16:0] after, logic last);
    result_t r;
    r.register_select = rs;
    r.nibble          = nib;
    r.wait_before_us  = pre_wait;
    r.wait_after_us   = after;
    r.last            = last;
    nibble_q.push_back(r);
  endfunction

  function automatic void push_byte(logic rs, logic [7:0] b, logic last);
    push_nibble(rs, b[7:4], 20'd0, 17'(settle_us), 1'b0);
    push_nibble(rs, b[3:0], 20'd0, 17'(settle_us), last);
  endfunction

  function automatic void lcd_transfers(item_t it);
    logic [17:0]     init_after;
    logic [6:0]      addr;
    logic [15:0]     v;
    logic [3:0][7:0] ch;
    init_after = 18'(settle_us) + 18'(init_wait_us);
    if (init_after > AFTER_CEILING) init_after = AFTER_CEILING;
    case (it.action)
      ACT_INIT: begin
        for (int i = 0; i < 5; i++) begin
          push_nibble(1'b0, INIT_SEQ[i][7:4], (i == 0) ? power_up_us : 20'd0,
                      17'(settle_us), 1'b0);
          push_nibble(1'b0, INIT_SEQ[i][3:0], 20'd0, init_after[16:0], i == 4);
        end
      end
      ACT_CLEAR:  push_byte(1'b0, CLEAR_CMD, 1'b1);
      ACT_CMD:    push_byte(1'b0, it.byte_value, 1'b1);
      ACT_DATA:   push_byte(1'b1, it.byte_value, 1'b1);
      ACT_CURSOR: begin
        addr = 7'(it.column) + (it.line_index ? LINE1_BASE : 7'd0);
        push_byte(1'b0, SET_ADDR_CMD | {1'b0, addr}, 1'b1);
      end
      ACT_PRINT: begin
        v = it.number % 16'd10000;
        ch[0] = ASCII_ZERO + 8'(v / 1000);
        ch[1] = ASCII_ZERO + 8'((v / 100) % 10);
        ch[2] = ASCII_ZERO + 8'((v / 10) % 10);
        ch[3] = ASCII_ZERO + 8'(v % 10);
        // blanking looks at the full value, not the wrapped one
        if (it.number < 16'd1000) ch[0] = ASCII_SPACE;
        if (it.number < 16'd100)  ch[1] = ASCII_SPACE;
        if (it.number < 16'd10)   ch[2] = ASCII_SPACE;
        for (int i = 0; i < 4; i++) push_byte(1'b1, ch[i], i == 3);
      end
      default: ;  // spare codes send nothing
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // result checking
  // --------------------------------------------------------------------------
  task automatic note_mismatch(string field, logic [19:0] want, logic [19:0] got);
    err_count++;
    if (err_count <= REPORT_LIMIT)
      $display("mismatch %s: expected 0x%0h got 0x%0h", field, want, got);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      got_r = result_o;
      if (nibble_q.size() == 0) begin
        err_count++;
        if (err_count <= REPORT_LIMIT)
          $display("unexpected nibble transfer: %p", got_r);
      end else begin
        want_r = nibble_q.pop_front();
        if (got_r.register_select !== want_r.register_select)
          note_mismatch("register_select", 20'(want_r.register_select),
                        20'(got_r.register_select));
        if (got_r.nibble !== want_r.nibble)
          note_mismatch("nibble", 20'(want_r.nibble), 20'(got_r.nibble));
        if (got_r.wait_before_us !== want_r.wait_before_us)
          note_mismatch("wait_before_us", want_r.wait_before_us, got_r.wait_before_us);
        if (got_r.wait_after_us !== want_r.wait_after_us)
          note_mismatch("wait_after_us", 20'(want_r.wait_after_us),
                        20'(got_r.wait_after_us));
        if (got_r.last !== want_r.last)
          note_mismatch("last", 20'(want_r.last), 20'(got_r.last));
      end
    end
  end

  // no item taken and no nibble seen for too long
  always @(posedge clk_i) begin
    if ((start && !busy) || result_valid_o) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // drivers
  // --------------------------------------------------------------------------
  task automatic send_item(item_t it, bit allow_idle);
    int unsigned gap;
    if (allow_idle && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 3);
      repeat (gap) begin
        @(negedge clk_i);
        start <= 1'b0;
      end
    end
    @(negedge clk_i);
    start  <= 1'b1;
    item_i <= it;
    do @(posedge clk_i); while (busy);
  endtask

  // drop start and let every pending nibble arrive
  task automatic drain_nibbles();
    @(negedge clk_i);
    start <= 1'b0;
    while (nibble_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic apb_write(reg_idx_e idx, logic [31:0] val);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    case (idx)
      REG_SETTLE:    settle_us    = val[9:0];
      REG_INIT_WAIT: init_wait_us = val[16:0];
      REG_POWER_UP:  power_up_us  = val[19:0];
      default: ;
    endcase
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_timing(logic [31:0] settle, logic [31:0] init_w, logic [31:0] power);
    repeat (SETTLE_GAP) @(posedge clk_i);
    apb_write(REG_SETTLE, settle);
    apb_write(REG_INIT_WAIT, init_w);
    apb_write(REG_POWER_UP, power);
  endtask

  function automatic item_t rand_item();
    item_t it;
    if ($urandom_range(0, 15) == 0)
      it.action = $urandom_range(0, 1) ? ACT_SPARE_HI : ACT_SPARE_LO;
    else
      it.action = 3'($urandom_range(ACT_INIT, ACT_PRINT));
    it.byte_value = 8'($urandom);
    it.column     = ($urandom_range(0, 7) == 0) ? 6'($urandom_range(40, 63))
                                                : 6'($urandom_range(0, 39));
    it.line_index = 1'($urandom);
    case ($urandom_range(0, 3))
      0:       it.number = 16'($urandom_range(0, 9));
      1:       it.number = 16'($urandom_range(0, 999));
      2:       it.number = 16'($urandom_range(0, 9999));
      default: it.number = 16'($urandom);
    endcase
    return it;
  endfunction

  task automatic run_random(int unsigned count, bit allow_idle);
    item_t       it;
    int unsigned sent;
    sent = 0;
    while (sent < count) begin
      it = rand_item();
      send_item(it, allow_idle);
      lcd_transfers(it);
      if (it.action <= ACT_PRINT) sent++;
      if (allow_idle && $urandom_range(0, 24) == 0) drain_nibbles();
    end
  endtask

  function automatic dir_row_t mk_row(row_kind_e kind, logic [2:0] act, logic [7:0] bv,
                                      logic [5:0] col, logic ln, logic [15:0] num,
                                      logic rs, logic [7:0] b);
    dir_row_t row;
    row.kind          = kind;
    row.it.action     = act;
    row.it.byte_value = bv;
    row.it.column     = col;
    row.it.line_index = ln;
    row.it.number     = num;
    row.rs            = rs;
    row.b             = b;
    return row;
  endfunction

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------
  initial begin
    rst_ni       = 1'b0;
    start        = 1'b0;
    item_i       = '0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    err_count    = 0;
    idle_cycles  = 0;
    settle_us    = 10'd100;
    init_wait_us = 17'd20000;
    power_up_us  = 20'd450000;

    // byte rows carry the command or character byte sent twice as nibbles
    directed_rows.push_back(mk_row(ROW_PREDICT, ACT_INIT,   8'h00, 6'd0,  1'b0, 16'd0, 1'b0, 8'h00));
    directed_rows.push_back(mk_row(ROW_BYTE,    ACT_CLEAR,  8'hFF, 6'd63, 1'b1, 16'hFFFF,
                                   1'b0, 8'h01));
    directed_rows.push_back(mk_row(ROW_BYTE,    ACT_CMD,    8'h00, 6'd0,  1'b0, 16'd0, 1'b0, 8'h00));
    directed_rows.push_back(mk_row(ROW_BYTE,    ACT_CMD,    8'hFF, 6'd0,  1'b0, 16'd0, 1'b0, 8'hFF));
    directed_rows.push_back(mk_row(ROW_BYTE,    ACT_DATA,   8'h00, 6'd0,  1'b0, 16'd0, 1'b1, 8'h00));
    directed_rows.push_back(mk_row(ROW_BYTE,    ACT_DATA,   8'hFF, 6'd0,  1'b0, 16'd0, 1'b1, 8'hFF));
    directed_rows.push_back(mk_row(ROW_BYTE,    ACT_DATA,   8'hA5, 6'd0,  1'b0, 16'd0, 1'b1, 8'hA5));
    directed_rows.push_back(mk_row(ROW_BYTE,    ACT_CURSOR, 8'h00, 6'd0,  1'b0, 16'd0, 1'b0, 8'h80));
    directed_rows.push_back(mk_row(ROW_BYTE,    ACT_CURSOR, 8'h00, 6'd39, 1'b1, 16'd0, 1'b0, 8'hE7));
    // column past the line end is added to the line base unchecked in the 7-bit address
    directed_rows.push_back(mk_row(ROW_BYTE,    ACT_CURSOR, 8'h00, 6'd63, 1'b1, 16'd0, 1'b0, 8'hFF));
    directed_rows.push_back(mk_row(ROW_BYTE,    ACT_CURSOR, 8'h00, 6'd63, 1'b0, 16'd0, 1'b0, 8'hBF));
    directed_rows.push_back(mk_row(ROW_PREDICT, ACT_PRINT,  8'h00, 6'd0,  1'b0, 16'd0, 1'b0, 8'h00));
    directed_rows.push_back(mk_row(ROW_PREDICT, ACT_PRINT,  8'h00, 6'd0,  1'b0, 16'd9, 1'b0, 8'h00));
    directed_rows.push_back(mk_row(ROW_PREDICT, ACT_PRINT,  8'h00, 6'd0,  1'b0, 16'd10, 1'b0, 8'h00));
    directed_rows.push_back(mk_row(ROW_PREDICT, ACT_PRINT,  8'h00, 6'd0,  1'b0, 16'd99, 1'b0, 8'h00));
    directed_rows.push_back(mk_row(ROW_PREDICT, ACT_PRINT,  8'h00, 6'd0,  1'b0, 16'd100, 1'b0, 8'h00));
    directed_rows.push_back(mk_row(ROW_PREDICT, ACT_PRINT,  8'h00, 6'd0,  1'b0, 16'd999, 1'b0, 8'h00));
    directed_rows.push_back(mk_row(ROW_PREDICT, ACT_PRINT,  8'h00, 6'd0,  1'b0, 16'd1000, 1'b0, 8'h00));
    directed_rows.push_back(mk_row(ROW_PREDICT, ACT_PRINT,  8'h00, 6'd0,  1'b0, 16'd9999, 1'b0, 8'h00));
    // wraps to zero but is not blanked
    directed_rows.push_back(mk_row(ROW_PREDICT, ACT_PRINT,  8'h00, 6'd0,  1'b0, 16'd10000, 1'b0, 8'h00));
    directed_rows.push_back(mk_row(ROW_PREDICT, ACT_PRINT,  8'h00, 6'd0,  1'b0, 16'd10005, 1'b0, 8'h00));
    directed_rows.push_back(mk_row(ROW_PREDICT, ACT_PRINT,  8'h00, 6'd0,  1'b0, 16'hFFFF, 1'b0, 8'h00));
    directed_rows.push_back(mk_row(ROW_NONE,    ACT_SPARE_LO, 8'hFF, 6'd63, 1'b1, 16'hFFFF,
                                   1'b0, 8'h00));
    directed_rows.push_back(mk_row(ROW_NONE,    ACT_SPARE_HI, 8'h00, 6'd0, 1'b0, 16'd0,
                                   1'b0, 8'h00));

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (directed_rows[i]) begin
      send_item(directed_rows[i].it, 1'b1);
      case (directed_rows[i].kind)
        ROW_BYTE:    push_byte(directed_rows[i].rs, directed_rows[i].b, 1'b1);
        ROW_PREDICT: lcd_transfers(directed_rows[i].it);
        default: ;
      endcase
    end
    drain_nibbles();

    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: set_timing(32'd0, 32'd0, 32'd0);
        1: set_timing(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);  // masked, saturates
        2: set_timing(32'd1000, 32'd100000, 32'd1000000);
        3: set_timing($urandom_range(0, 1000), $urandom_range(0, 100000),
                      $urandom_range(0, 1000000));
        default: set_timing($urandom, $urandom, $urandom);
      endcase
      // last phase runs back to back
      run_random(PHASE_ITEMS, p != NUM_PHASES - 1);
      drain_nibbles();
    end

    repeat (SETTLE_GAP) @(posedge clk_i);
    if (err_count == 0 && nibble_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
